/* design/sha1bsh_pkg.sv */
// Shared types and constants of the SHA-1 byte stream hasher.
package sha1bsh_pkg;

   // Initial chaining values of SHA-1.
   localparam logic [31:0] IV_H0 = 32'h67452301;
   localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
   localparam logic [31:0] IV_H2 = 32'h98BADCFE;
   localparam logic [31:0] IV_H3 = 32'h10325476;
   localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

   // Round constants, one for each group of twenty rounds.
   localparam logic [31:0] ROUND_K0 = 32'h5A827999;
   localparam logic [31:0] ROUND_K1 = 32'h6ED9EBA1;
   localparam logic [31:0] ROUND_K2 = 32'h8F1BBCDC;
   localparam logic [31:0] ROUND_K3 = 32'hCA62C1D6;

   // Padding marker byte and block geometry.
   localparam logic [7:0] PAD_MARK      = 8'h80;
   localparam logic [5:0] FILL_LAST     = 6'd63;
   localparam logic [5:0] FILL_LEN_POS  = 6'd56;
   localparam logic [6:0] ROUND_LAST    = 7'd79;
   localparam logic [6:0] ROUND_PHASE1  = 7'd20;
   localparam logic [6:0] ROUND_PHASE2  = 7'd40;
   localparam logic [6:0] ROUND_PHASE3  = 7'd60;
   localparam logic [2:0] LEN_BYTE_LAST = 3'd7;
   localparam logic [2:0] WORD_LAST     = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } ctrl_state_type;

   // Source of the byte shifted into the block buffer.
   typedef enum logic [1:0] {
      BSEL_DATA,
      BSEL_MARK,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   // Round function group.
   typedef enum logic [1:0] {
      PH_CHOOSE,
      PH_PARITY1,
      PH_MAJORITY,
      PH_PARITY2
   } round_phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load_byte;
      byte_sel_type    byte_sel;
      logic [2:0]      len_idx;
      logic            count_len;
      logic            round_en;
      logic            round_first;
      round_phase_type phase;
      logic            add_chain;
      logic            hash_init;
      logic [2:0]      word_idx;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_last;
      logic fill_at_len;
   } dp_status_type;

endpackage

/* design/sha1bsh_datapath.sv */
// Datapath of the SHA-1 hasher: block buffer, length counter, round unit and chaining words.
module sha1bsh_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              data_byte,
   input  sha1bsh_pkg::dp_cmd_type cmd,
   output sha1bsh_pkg::dp_status_type status,
   output logic [31:0]             digest_word
);

   // The 64-byte block is a shift line; during compression it shifts by words
   // and serves as the sixteen-word message schedule, oldest word at the top.
   logic [511:0] buf_ff, buf_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in;
   logic [31:0]  chain_ff [5];
   logic [31:0]  chain_in [5];
   logic [31:0]  work_ff [5];
   logic [31:0]  work_in [5];

   logic [7:0]  byte_val;
   logic [31:0] cur_a, cur_b, cur_c, cur_d, cur_e;
   logic [31:0] f_val, k_val, sched_x, w_next, w_now, t_sum;

   // Byte source selection.
   always_comb begin
      case (cmd.byte_sel)
         sha1bsh_pkg::BSEL_DATA: byte_val = data_byte;
         sha1bsh_pkg::BSEL_MARK: byte_val = sha1bsh_pkg::PAD_MARK;
         sha1bsh_pkg::BSEL_ZERO: byte_val = 8'h00;
         sha1bsh_pkg::BSEL_LEN:  byte_val = len_ff[{~cmd.len_idx, 3'b000} +: 8];
         default:                byte_val = 8'h00;
      endcase
   end

   // Working variables: the first round starts from the chaining words.
   assign cur_a = cmd.round_first ? chain_ff[0] : work_ff[0];
   assign cur_b = cmd.round_first ? chain_ff[1] : work_ff[1];
   assign cur_c = cmd.round_first ? chain_ff[2] : work_ff[2];
   assign cur_d = cmd.round_first ? chain_ff[3] : work_ff[3];
   assign cur_e = cmd.round_first ? chain_ff[4] : work_ff[4];

   // Round function and constant for the current group of rounds.
   always_comb begin
      case (cmd.phase)
         sha1bsh_pkg::PH_CHOOSE: begin
            f_val = (cur_b & cur_c) | (~cur_b & cur_d);
            k_val = sha1bsh_pkg::ROUND_K0;
         end
         sha1bsh_pkg::PH_PARITY1: begin
            f_val = cur_b ^ cur_c ^ cur_d;
            k_val = sha1bsh_pkg::ROUND_K1;
         end
         sha1bsh_pkg::PH_MAJORITY: begin
            f_val = (cur_b & cur_c) | (cur_b & cur_d) | (cur_c & cur_d);
            k_val = sha1bsh_pkg::ROUND_K2;
         end
         sha1bsh_pkg::PH_PARITY2: begin
            f_val = cur_b ^ cur_c ^ cur_d;
            k_val = sha1bsh_pkg::ROUND_K3;
         end
         default: begin
            f_val = cur_b ^ cur_c ^ cur_d;
            k_val = sha1bsh_pkg::ROUND_K3;
         end
      endcase
   end

   // Message schedule: the word in use and the word sixteen rounds ahead.
   assign w_now   = buf_ff[511:480];
   assign sched_x = buf_ff[95:64] ^ buf_ff[255:224] ^ buf_ff[447:416] ^ buf_ff[511:480];
   assign w_next  = {sched_x[30:0], sched_x[31]};
   assign t_sum   = {cur_a[26:0], cur_a[31:27]} + f_val + cur_e + w_now + k_val;

   // Next-state logic of the datapath registers.
   always_comb begin
      buf_in  = buf_ff;
      fill_in = fill_ff;
      len_in  = len_ff;
      for (int i = 0; i < 5; i++) begin
         chain_in[i] = chain_ff[i];
         work_in[i]  = work_ff[i];
      end
      if (cmd.load_byte) begin
         buf_in  = {buf_ff[503:0], byte_val};
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count_len) begin
         len_in = len_ff + 64'd8;
      end
      if (cmd.round_en) begin
         buf_in     = {buf_ff[479:0], w_next};
         work_in[0] = t_sum;
         work_in[1] = cur_a;
         work_in[2] = {cur_b[1:0], cur_b[31:2]};
         work_in[3] = cur_c;
         work_in[4] = cur_d;
      end
      if (cmd.add_chain) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.hash_init) begin
         fill_in     = 6'd0;
         len_in      = 64'd0;
         chain_in[0] = sha1bsh_pkg::IV_H0;
         chain_in[1] = sha1bsh_pkg::IV_H1;
         chain_in[2] = sha1bsh_pkg::IV_H2;
         chain_in[3] = sha1bsh_pkg::IV_H3;
         chain_in[4] = sha1bsh_pkg::IV_H4;
      end
   end

   // Counters and chaining words are reset; buffer and working words are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= 6'd0;
         len_ff      <= 64'd0;
         chain_ff[0] <= sha1bsh_pkg::IV_H0;
         chain_ff[1] <= sha1bsh_pkg::IV_H1;
         chain_ff[2] <= sha1bsh_pkg::IV_H2;
         chain_ff[3] <= sha1bsh_pkg::IV_H3;
         chain_ff[4] <= sha1bsh_pkg::IV_H4;
      end else begin
         fill_ff  <= fill_in;
         len_ff   <= len_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      work_ff <= work_in;
   end

   // Status towards the controller.
   assign status.fill_last   = (fill_ff == sha1bsh_pkg::FILL_LAST);
   assign status.fill_at_len = (fill_ff == sha1bsh_pkg::FILL_LEN_POS);

   // Digest word selection.
   always_comb begin
      case (cmd.word_idx)
         3'd0:    digest_word = chain_ff[0];
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[4];
      endcase
   end

endmodule

/* design/sha1bsh_ctrl.sv */
// Controller of the SHA-1 hasher: request intake, padding sequence, rounds and digest output.
module sha1bsh_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       has_byte,
   input  logic                       end_of_message,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 word_number,
   output logic                       last_word,
   input  sha1bsh_pkg::dp_status_type status,
   output sha1bsh_pkg::dp_cmd_type    cmd
);

   sha1bsh_pkg::ctrl_state_type state_ff, state_in;
   sha1bsh_pkg::ctrl_state_type ret_ff, ret_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] len_idx_ff, len_idx_in;
   logic [2:0] word_ff, word_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha1bsh_pkg::ST_IDLE;
         ret_ff     <= sha1bsh_pkg::ST_IDLE;
         round_ff   <= 7'd0;
         len_idx_ff <= 3'd0;
         word_ff    <= 3'd0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         round_ff   <= round_in;
         len_idx_ff <= len_idx_in;
         word_ff    <= word_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      round_in   = round_ff;
      len_idx_in = len_idx_ff;
      word_in    = word_ff;

      cmd             = '0;
      cmd.byte_sel    = sha1bsh_pkg::BSEL_DATA;
      cmd.len_idx     = len_idx_ff;
      cmd.word_idx    = word_ff;
      cmd.round_first = (round_ff == 7'd0);
      if (round_ff < sha1bsh_pkg::ROUND_PHASE1) begin
         cmd.phase = sha1bsh_pkg::PH_CHOOSE;
      end else if (round_ff < sha1bsh_pkg::ROUND_PHASE2) begin
         cmd.phase = sha1bsh_pkg::PH_PARITY1;
      end else if (round_ff < sha1bsh_pkg::ROUND_PHASE3) begin
         cmd.phase = sha1bsh_pkg::PH_MAJORITY;
      end else begin
         cmd.phase = sha1bsh_pkg::PH_PARITY2;
      end

      case (state_ff)
         // Take one request: append its byte if it has one, then compress or start padding.
         sha1bsh_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_byte = has_byte;
               cmd.count_len = has_byte;
               if (has_byte && status.fill_last) begin
                  state_in = sha1bsh_pkg::ST_ROUND;
                  round_in = 7'd0;
                  ret_in   = end_of_message ? sha1bsh_pkg::ST_PAD_MARK : sha1bsh_pkg::ST_IDLE;
               end else if (end_of_message) begin
                  state_in = sha1bsh_pkg::ST_PAD_MARK;
               end
            end
         end
         // Append the end-of-message marker.
         sha1bsh_pkg::ST_PAD_MARK: begin
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = sha1bsh_pkg::BSEL_MARK;
            if (status.fill_last) begin
               state_in = sha1bsh_pkg::ST_ROUND;
               round_in = 7'd0;
               ret_in   = sha1bsh_pkg::ST_PAD_ZERO;
            end else begin
               state_in = sha1bsh_pkg::ST_PAD_ZERO;
            end
         end
         // Zero bytes up to the length field, spilling into a second block if needed.
         sha1bsh_pkg::ST_PAD_ZERO: begin
            if (status.fill_at_len) begin
               state_in = sha1bsh_pkg::ST_PAD_LEN;
            end else begin
               cmd.load_byte = 1'b1;
               cmd.byte_sel  = sha1bsh_pkg::BSEL_ZERO;
               if (status.fill_last) begin
                  state_in = sha1bsh_pkg::ST_ROUND;
                  round_in = 7'd0;
                  ret_in   = sha1bsh_pkg::ST_PAD_ZERO;
               end
            end
         end
         // Eight length bytes, most significant first, then the final compression.
         sha1bsh_pkg::ST_PAD_LEN: begin
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = sha1bsh_pkg::BSEL_LEN;
            len_idx_in    = len_idx_ff + 3'd1;
            if (len_idx_ff == sha1bsh_pkg::LEN_BYTE_LAST) begin
               state_in = sha1bsh_pkg::ST_ROUND;
               round_in = 7'd0;
               ret_in   = sha1bsh_pkg::ST_OUT;
            end
         end
         // One compression round per cycle.
         sha1bsh_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == sha1bsh_pkg::ROUND_LAST) begin
               state_in = sha1bsh_pkg::ST_ADD;
            end
         end
         // Fold the working words into the chaining words.
         sha1bsh_pkg::ST_ADD: begin
            cmd.add_chain = 1'b1;
            state_in      = ret_ff;
         end
         // Present the digest one word at a time.
         sha1bsh_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == sha1bsh_pkg::WORD_LAST) begin
                  word_in       = 3'd0;
                  cmd.hash_init = 1'b1;
                  state_in      = sha1bsh_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1bsh_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake outputs come straight from the state register.
   assign req_stall   = (state_ff != sha1bsh_pkg::ST_IDLE);
   assign rsp_valid   = (state_ff == sha1bsh_pkg::ST_OUT);
   assign word_number = word_ff;
   assign last_word   = (word_ff == sha1bsh_pkg::WORD_LAST);

endmodule

/* design/sha1_byte_stream_hasher.sv */
// Top level of the SHA-1 byte stream hasher.
// SHA-1 hasher fed one message byte per request; a request with end_of_message set closes the
// message and the block answers with the five digest words, word 0 (most significant) first,
// then returns to the initial hash state. A request carrying a byte is taken while req_stall is
// low; the request that completes a 64-byte block starts its compression, which runs one round
// per cycle through a single round unit and then adds the chaining words. Closing a message
// takes the marker byte, the zero bytes up to the length field, eight length bytes, one or two
// compressions and five response words. While a block is compressed, padded or the digest is
// presented, req_stall is held high.
module sha1_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);

   sha1bsh_pkg::dp_cmd_type    cmd;
   sha1bsh_pkg::dp_status_type status;

   // Sequencing of requests, padding, rounds and output.
   sha1bsh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .has_byte       (req_has_byte),
      .end_of_message (req_end_of_message),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .word_number    (rsp_word_number),
      .last_word      (rsp_last_word),
      .status         (status),
      .cmd            (cmd)
   );

   // Block buffer, length, round unit and chaining words.
   sha1bsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_data_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

`ifndef ASSERT_OFF
   // No request is taken while a digest is being presented.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request side open while digest is presented");

   // Digest words follow one another in order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_word) |=>
         (rsp_valid && (rsp_word_number == $past(rsp_word_number) + 3'd1)))
      else $error("digest word sequence broken");

   // The response ends after the last word is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word) |=> (!rsp_valid && !req_stall))
      else $error("response continues after last digest word");

   // The last word is word four.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_word) |-> (rsp_word_number == 3'd4))
      else $error("last word flagged at wrong position");
`endif

endmodule
